### src/srpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srpp_pkg;

  // Characters the grammar reacts to.
  localparam logic [7:0] ChOpen  = 8'h3C;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChClose = 8'h3E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;

  // Grammar position.
  localparam logic [3:0] PhLead       = 4'd0;
  localparam logic [3:0] PhOpened     = 4'd1;
  localparam logic [3:0] PhFirst      = 4'd2;
  localparam logic [3:0] PhFirstComma = 4'd3;
  localparam logic [3:0] PhRoute      = 4'd4;
  localparam logic [3:0] PhRouteComma = 4'd5;
  localparam logic [3:0] PhUser       = 4'd6;
  localparam logic [3:0] PhHostStart  = 4'd7;
  localparam logic [3:0] PhHost       = 4'd8;

  // Decision and verdict codes.
  localparam logic [1:0] DecPending  = 2'd0;
  localparam logic [1:0] DecAccepted = 2'd1;
  localparam logic [1:0] DecRejected = 2'd2;

  // Role codes.
  localparam logic [2:0] RoleDelim  = 3'd0;
  localparam logic [2:0] RoleFirst  = 3'd1;
  localparam logic [2:0] RoleRoute  = 3'd2;
  localparam logic [2:0] RoleUser   = 3'd3;
  localparam logic [2:0] RoleHost   = 3'd4;
  localparam logic [2:0] RoleIgnore = 3'd5;

  localparam int unsigned OutWidth = 8;

  typedef struct packed {
    logic [3:0] phase;
    logic [1:0] decision;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] role;
  } parse_result_t;

endpackage

`default_nettype wire

### src/srpp_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next state and per-character result of the path grammar.
module srpp_step (
  input  logic [7:0]            ch_i,
  input  srpp_pkg::parse_state_t cur_i,
  output srpp_pkg::parse_state_t nxt_o,
  output srpp_pkg::parse_result_t res_o
);
  import srpp_pkg::*;

  logic [2:0] role;

  always_comb begin
    nxt_o = cur_i;
    role  = RoleDelim;
    res_o = '0;
    if (ch_i == ChNul) begin
      nxt_o.phase    = PhLead;
      nxt_o.decision = DecPending;
      res_o.role     = RoleDelim;
      res_o.verdict  = (cur_i.decision == DecPending) ? DecRejected : cur_i.decision;
    end else if (cur_i.decision != DecPending) begin
      res_o.role    = RoleIgnore;
      res_o.verdict = cur_i.decision;
    end else begin
      case (cur_i.phase)
        PhLead: begin
          if (ch_i == ChOpen) begin
            nxt_o.phase = PhOpened;
          end else if (ch_i != ChSpace) begin
            nxt_o.decision = DecRejected;
          end
        end
        PhOpened, PhFirstComma, PhRouteComma: begin
          if (ch_i == ChAt) begin
            // An '@' right after '<' opens the first hop; after a comma, a route host.
            nxt_o.phase = (cur_i.phase == PhOpened) ? PhFirst : PhRoute;
            role        = (cur_i.phase == PhOpened) ? RoleFirst : RoleRoute;
          end else begin
            nxt_o.phase = PhUser;
            role        = RoleUser;
          end
        end
        PhFirst: begin
          if (ch_i == ChComma) begin
            nxt_o.phase = PhFirstComma;
          end else begin
            role = RoleFirst;
          end
        end
        PhRoute: begin
          if (ch_i == ChComma) begin
            nxt_o.phase = PhRouteComma;
          end else begin
            role = RoleRoute;
          end
        end
        PhUser: begin
          if (ch_i == ChAt) begin
            nxt_o.phase = PhHostStart;
          end else begin
            role = RoleUser;
          end
        end
        PhHostStart: begin
          if (ch_i == ChClose || ch_i == ChComma) begin
            nxt_o.decision = DecRejected;
          end else begin
            nxt_o.phase = PhHost;
            role        = RoleHost;
          end
        end
        PhHost: begin
          if (ch_i == ChClose) begin
            nxt_o.decision = DecAccepted;
          end else if (ch_i == ChComma) begin
            nxt_o.decision = DecRejected;
          end else begin
            role = RoleHost;
          end
        end
        default: begin
          nxt_o.decision = DecRejected;
        end
      endcase
      // A user-name '@' in the three route-entry phases would be a delimiter, but an '@' there always opens a hop.
      if ((cur_i.phase == PhFirstComma || cur_i.phase == PhRouteComma ||
           cur_i.phase == PhOpened) && ch_i == ChAt && nxt_o.phase == PhUser) begin
        role = RoleDelim;
      end
      res_o.role    = role;
      res_o.verdict = nxt_o.decision;
    end
  end

endmodule

`default_nettype wire

### src/srpp_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-word result buffer that lets the input side keep accepting while a
// result waits for the downstream side.
module srpp_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  srpp_pkg::parse_result_t data_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  logic                    pop_ready_i,
  output srpp_pkg::parse_result_t data_o
);
  import srpp_pkg::*;

  parse_result_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### src/source_route_path_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for mail paths of the form <@h1,@h2,user@host>. Each
// accepted input word carries one character, and each produces exactly one
// output word with the role of that character (0 skipped or delimiter,
// 1 first hop, 2 route host, 3 user name, 4 host name, 5 ignored after the
// verdict) and the verdict so far (0 still parsing, 1 accepted, 2 rejected).
// A zero byte ends the string, reports rejected if no verdict was reached,
// and re-arms the parser. The block takes one character per cycle: the
// grammar position and decision registers update in the cycle a word is
// accepted, and the result lands in a two-word output buffer, so input
// stalls only when two results are waiting downstream. Output valid is high
// in the cycle after an input word is accepted.
module source_route_path_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] ch
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [2:0] role, [4:3] verdict, [7:5] zero
);
  import srpp_pkg::*;

  parse_state_t  state_q, state_d;
  parse_result_t step_res;
  parse_result_t buf_res;
  logic          in_fire;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Grammar step for the character on the input bus.
  srpp_step u_step (
    .ch_i  (s_axis_tdata_i),
    .cur_i (state_q),
    .nxt_o (state_d),
    .res_o (step_res)
  );

  // The state moves only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase    <= PhLead;
      state_q.decision <= DecPending;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  srpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .data_i      (step_res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (buf_res)
  );

  assign m_axis_tdata_o = {{(OutWidth - $bits(parse_result_t)){1'b0}}, buf_res};

  // A full buffer always has a word on offer.
  a_full_has_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no output pending");

  // A zero byte re-arms the parser.
  a_nul_rearms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tdata_i == ChNul) |=>
      (state_q.phase == PhLead && state_q.decision == DecPending))
    else $error("zero byte did not re-arm the parser");

  // Results on offer carry only defined codes.
  a_codes_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[4:3] <= DecRejected &&
                         m_axis_tdata_o[2:0] <= RoleIgnore))
    else $error("undefined role or verdict code");

  // Once decided, a non-zero character leaves the decision untouched.
  a_decision_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tdata_i != ChNul && state_q.decision != DecPending) |=>
      $stable(state_q))
    else $error("decided state changed on a non-zero character");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

// Checks the mail path parser one character at a time. The stream carries
// whole strings that end in a zero byte: a few handpicked ones first, then
// random paths that mostly follow the grammar, with broken and noisy ones
// among them. Each accepted character goes through a predictor of the path
// grammar. The monitor compares every output word with the oldest prediction.
module testbench;
  import srpp_pkg::*;

  localparam int unsigned RandomChars = 1900;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  // One predicted output word, kept with the character that caused it so
  // that a mismatch report can show it.
  typedef struct packed {
    logic [7:0]    ch;
    parse_result_t res;
  } char_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       out_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;   // [2:0] role, [4:3] verdict, [7:5] zero

  // Characters still to be sent, and results predicted but not yet seen.
  logic [7:0]   char_stream[$];
  char_result_t predicted_results[$];

  // Predictor copy of the grammar position and the decision.
  logic [3:0] path_phase = PhLead;
  logic [1:0] path_decision = DecPending;

  int unsigned total_chars = 0;
  int unsigned chars_sent = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  source_route_path_parser_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_ch),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A character that either extends the user name or, if it is '@', ends it
  // and opens the host name.
  function automatic logic [2:0] user_or_at(input logic [7:0] c);
    if (c == ChAt) begin
      path_phase = PhHostStart;
      return RoleDelim;
    end
    path_phase = PhUser;
    return RoleUser;
  endfunction

  // Predicts the role and verdict of one character and advances the grammar.
  function automatic parse_result_t step_path(input logic [7:0] c);
    parse_result_t r;
    r.role = RoleDelim;
    // A zero byte reports the decision, or rejected if the string ended
    // before one was reached, and re-arms the parser.
    if (c == ChNul) begin
      r.verdict = (path_decision == DecPending) ? DecRejected : path_decision;
      path_phase = PhLead;
      path_decision = DecPending;
      return r;
    end
    // Once decided, everything up to the zero byte is ignored.
    if (path_decision != DecPending) begin
      r.role = RoleIgnore;
      r.verdict = path_decision;
      return r;
    end
    case (path_phase)
      PhLead: begin
        if (c == ChOpen) begin
          path_phase = PhOpened;
        end else if (c != ChSpace) begin
          path_decision = DecRejected;
        end
      end
      PhOpened: begin
        if (c == ChAt) begin
          path_phase = PhFirst;
          r.role = RoleFirst;
        end else begin
          r.role = user_or_at(c);
        end
      end
      PhFirst: begin
        if (c == ChComma) begin
          path_phase = PhFirstComma;
        end else begin
          r.role = RoleFirst;
        end
      end
      PhFirstComma, PhRouteComma: begin
        if (c == ChAt) begin
          path_phase = PhRoute;
          r.role = RoleRoute;
        end else begin
          r.role = user_or_at(c);
        end
      end
      PhRoute: begin
        if (c == ChComma) begin
          path_phase = PhRouteComma;
        end else begin
          r.role = RoleRoute;
        end
      end
      PhUser: begin
        r.role = user_or_at(c);
      end
      PhHostStart: begin
        // The host may not be empty and may not start with a comma.
        if (c == ChClose || c == ChComma) begin
          path_decision = DecRejected;
        end else begin
          path_phase = PhHost;
          r.role = RoleHost;
        end
      end
      PhHost: begin
        if (c == ChClose) begin
          path_decision = DecAccepted;
        end else if (c == ChComma) begin
          path_decision = DecRejected;
        end else begin
          r.role = RoleHost;
        end
      end
      default: begin
        path_decision = DecRejected;
      end
    endcase
    r.verdict = path_decision;
    return r;
  endfunction

  // Idle percentage for the sender or the receiver. The run goes through
  // three stretches: sender idles less than receiver, then the reverse, and
  // finally both run at full rate.
  function automatic int unsigned idle_pct(input bit receiver);
    if (chars_sent < total_chars / 3) begin
      return receiver ? 57 : 33;
    end else if (chars_sent < 2 * total_chars / 3) begin
      return receiver ? 33 : 57;
    end
    return 0;
  endfunction

  // A nonzero character, biased toward the ones the grammar reacts to, that
  // is neither of the two given characters.
  function automatic logic [7:0] pick_char(input logic [7:0] bar_a,
                                           input logic [7:0] bar_b);
    logic [7:0] c;
    do begin
      case ($urandom_range(3))
        0: c = 8'($urandom_range(255, 1));
        1: c = 8'(8'h61 + $urandom_range(25));
        default: begin
          case ($urandom_range(4))
            0: c = ChOpen;
            1: c = ChAt;
            2: c = ChComma;
            3: c = ChClose;
            default: c = ChSpace;
          endcase
        end
      endcase
    end while (c == bar_a || c == bar_b);
    return c;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_stream.push_back(s[i]);
    end
  endtask

  // Appends one string. Most are paths built by the grammar with random
  // content: leading spaces, a source route of up to three hops, a user
  // name, a host and the closing bracket. Some get a comma in the host, lose
  // the closing bracket, have one character replaced or are cut short. A
  // tenth are plain noise, zero bytes included.
  task automatic add_random_path();
    logic [7:0]  seq[$];
    int unsigned cut;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(6, 1)) seq.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) seq.push_back(ChSpace);
      seq.push_back(($urandom_range(11) == 0) ? pick_char(ChOpen, ChNul) : ChOpen);
      repeat ($urandom_range(3)) begin
        seq.push_back(ChAt);
        repeat ($urandom_range(3)) seq.push_back(pick_char(ChComma, ChNul));
        seq.push_back(ChComma);
      end
      repeat ($urandom_range(4)) seq.push_back(pick_char(ChAt, ChNul));
      seq.push_back(ChAt);
      repeat ($urandom_range(4)) seq.push_back(pick_char(ChComma, ChClose));
      if ($urandom_range(7) == 0) seq.push_back(ChComma);
      if ($urandom_range(7) != 0) seq.push_back(ChClose);
      repeat ($urandom_range(2)) seq.push_back(pick_char(ChNul, ChNul));
      if ($urandom_range(5) == 0) begin
        seq[$urandom_range(seq.size() - 1)] = pick_char(ChNul, ChNul);
      end
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(seq.size() - 1, 1);
        while (seq.size() > cut) seq.pop_back();
      end
    end
    seq.push_back(ChNul);
    foreach (seq[i]) char_stream.push_back(seq[i]);
  endtask

  // Driver: on acceptance the character goes through the predictor, then
  // the next one is offered unless the sender idles this cycle. A word that
  // is offered is held until it is taken.
  always @(posedge clk_i) begin : drive_blk
    char_result_t pred;
    if (rst_ni) begin
      if (in_valid && s_axis_tready_o) begin
        pred.ch = in_ch;
        pred.res = step_path(in_ch);
        predicted_results.push_back(pred);
        chars_sent++;
      end
      if (!in_valid || s_axis_tready_o) begin
        if (char_stream.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_ch <= char_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every word taken from the output is checked field by field
  // against the oldest prediction, the zero fill included.
  always @(posedge clk_i) begin : watch_blk
    char_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && out_ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: output word %02h with no character waiting for it",
                   $time, m_axis_tdata_o);
        end else begin
          want = predicted_results.pop_front();
          if (m_axis_tdata_o[2:0] !== want.res.role) begin
            errors++;
            $display("%0t: char %02h role expected %0d, got %0d",
                     $time, want.ch, want.res.role, m_axis_tdata_o[2:0]);
          end
          if (m_axis_tdata_o[4:3] !== want.res.verdict) begin
            errors++;
            $display("%0t: char %02h verdict expected %0d, got %0d",
                     $time, want.ch, want.res.verdict, m_axis_tdata_o[4:3]);
          end
          if (m_axis_tdata_o[7:5] !== 3'b000) begin
            errors++;
            $display("%0t: char %02h fill bits expected 0, got %0d",
                     $time, want.ch, m_axis_tdata_o[7:5]);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // A zero byte before anything was decided: the string ended early.
    char_stream.push_back(ChNul);
    // A full path with spaces, two hops, user and host, and a character
    // ignored after the accept.
    push_text("  <@a,@b,u@h>z");
    char_stream.push_back(ChNul);
    // Rejected on the first character, then the stored reject at the end.
    push_text("q");
    char_stream.push_back(ChNul);
    // Extreme byte values inside the first hop and the user name, then an
    // empty host closed right away.
    char_stream.push_back(ChOpen);
    char_stream.push_back(ChAt);
    char_stream.push_back(8'hFF);
    char_stream.push_back(ChComma);
    char_stream.push_back(8'h80);
    char_stream.push_back(ChAt);
    char_stream.push_back(ChClose);
    char_stream.push_back(ChNul);

    while (char_stream.size() < RandomChars + 25) add_random_path();
    total_chars = char_stream.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_stream.size() != 0 || in_valid) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
